// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; b64c_fifo.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define B64C_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b64c assertion failed");

// The condition must never be true at a clock edge outside reset.
`define B64C_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("b64c assertion failed");

`endif

// ===== hw/rtl/b64c_pkg.sv =====
package b64c_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic REG_DIRECTION = 1'b0;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One queued job expands into cnt + 1 results.
  typedef struct packed {
    logic [3:0][7:0] vals;
    logic [1:0]      cnt;
    logic            present;
    logic            last;
  } job_t;

  function automatic logic [7:0] alphabet_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Returns {valid, sextet}; valid is low for anything outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64c_in_if.sv =====
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_value;
  logic       in_last;

  modport source (output valid, output in_value, output in_last, input ready);
  modport sink (input valid, input in_value, input in_last, output ready);
endinterface

// ===== hw/rtl/b64c_out_if.sv =====
interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       out_present;
  logic       out_last;

  modport source (output valid, output out_value, output out_present, output out_last,
                  input ready);
  modport sink (input valid, input out_value, input out_present, input out_last,
                output ready);
endinterface

// ===== hw/rtl/b64c_front.sv =====
module b64c_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  b64c_in_if.sink          in_i,
  input  logic             direction_i,
  input  logic             clear_i,
  input  logic             full_i,
  output logic             push_o,
  output b64c_pkg::job_t   job_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] held_q, held_d;
  logic       hvalid_q, hvalid_d;

  logic       accept;
  logic       has_job;
  logic [6:0] sext;
  logic [7:0] b;
  logic [7:0] dec_byte;
  logic       ok;
  logic       emit;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept && has_job;
  assign b          = in_i.in_value;
  assign sext       = b64c_pkg::sextet_of(in_i.in_value);
  assign ok         = sext[6];

  always_comb begin
    job_o    = '0;
    has_job  = 1'b0;
    pos_d    = pos_q;
    held_d   = held_q;
    hvalid_d = hvalid_q;
    dec_byte = 8'h00;
    emit     = 1'b0;
    job_o.last = in_i.in_last;
    if (direction_i == b64c_pkg::DIR_ENCODE) begin
      has_job       = 1'b1;
      job_o.present = 1'b1;
      hvalid_d      = 1'b0;
      unique case (pos_q)
        2'd0: begin
          job_o.vals[0] = b64c_pkg::alphabet_char(b[7:2]);
          held_d        = {4'b0000, b[1:0]};
          pos_d         = 2'd1;
          if (in_i.in_last) begin
            job_o.vals[1] = b64c_pkg::alphabet_char({b[1:0], 4'b0000});
            job_o.vals[2] = b64c_pkg::PAD_CHAR;
            job_o.vals[3] = b64c_pkg::PAD_CHAR;
            job_o.cnt     = 2'd3;
          end
        end
        2'd1: begin
          job_o.vals[0] = b64c_pkg::alphabet_char({held_q[1:0], b[7:4]});
          held_d        = {2'b00, b[3:0]};
          pos_d         = 2'd2;
          if (in_i.in_last) begin
            job_o.vals[1] = b64c_pkg::alphabet_char({b[3:0], 2'b00});
            job_o.vals[2] = b64c_pkg::PAD_CHAR;
            job_o.cnt     = 2'd2;
          end
        end
        2'd2, 2'd3: begin
          job_o.vals[0] = b64c_pkg::alphabet_char({held_q[3:0], b[7:6]});
          job_o.vals[1] = b64c_pkg::alphabet_char(b[5:0]);
          job_o.cnt     = 2'd1;
          held_d        = 6'd0;
          pos_d         = 2'd0;
        end
      endcase
    end else begin
      unique case (pos_q)
        2'd0: dec_byte = 8'h00;
        2'd1: dec_byte = {held_q, sext[5:4]};
        2'd2: dec_byte = {held_q[3:0], sext[5:2]};
        2'd3: dec_byte = {held_q[1:0], sext[5:0]};
      endcase
      emit          = ok && hvalid_q && (pos_q != 2'd0);
      job_o.vals[0] = emit ? dec_byte : 8'h00;
      job_o.present = emit;
      has_job       = emit || in_i.in_last;
      held_d        = ok ? sext[5:0] : 6'd0;
      hvalid_d      = ok;
      pos_d         = pos_q + 2'd1;
    end
    if (in_i.in_last) begin
      pos_d    = 2'd0;
      held_d   = 6'd0;
      hvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 2'd0;
      held_q   <= 6'd0;
      hvalid_q <= 1'b0;
    end else if (clear_i) begin
      pos_q    <= 2'd0;
      held_q   <= 6'd0;
      hvalid_q <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      held_q   <= held_d;
      hvalid_q <= hvalid_d;
    end
  end

endmodule

// ===== hw/rtl/b64c_fifo.sv =====
`include "assert_macros.svh"

module b64c_fifo #(
  parameter int unsigned DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64c_pkg::job_t push_job_i,
  output logic           full_o,
  output logic           valid_o,
  output b64c_pkg::job_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64c_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  `B64C_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `B64C_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `B64C_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)

endmodule

// ===== hw/rtl/b64c_back.sv =====
module b64c_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  b64c_pkg::job_t job_i,
  output logic           pop_o,
  b64c_out_if.source     out_o
);

  logic [1:0] idx_q;
  logic       ovalid_q;
  logic [7:0] value_q;
  logic       present_q;
  logic       last_q;

  logic load;
  logic emit;
  logic done;

  assign load  = !ovalid_q || out_o.ready;
  assign emit  = load && valid_i;
  assign done  = (idx_q == job_i.cnt);
  assign pop_o = emit && done;

  assign out_o.valid       = ovalid_q;
  assign out_o.out_value   = value_q;
  assign out_o.out_present = present_q;
  assign out_o.out_last    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      if (load) begin
        ovalid_q <= valid_i;
      end
      if (emit) begin
        idx_q <= done ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q   <= job_i.vals[idx_q];
      present_q <= job_i.present;
      last_q    <= job_i.last && done;
    end
  end

endmodule

// ===== hw/rtl/base64_stream_codec.sv =====
// Channel  Direction  Payload                          Transaction
// in_i     input      in_value, in_last                valid && ready
// out_o    output     out_value, out_present, out_last valid && ready
// apb      input      direction register at offset 0   psel && penable && pwrite
//
// The front end takes one item per cycle while the job queue has room.
// The back end sends one result per cycle while out_o is ready, so an encoded
// byte yields one to four results and a long message four results per three bytes.
// The first result of an item passes through the job queue and the output register.
// Reset clears the direction to encode and empties the queue; a stall on
// out_o fills the queue and then holds in_i.ready low.
module base64_stream_codec #(
  parameter int unsigned QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  b64c_in_if.sink                        in_i,
  b64c_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [b64c_pkg::PADDR_W-1:0]   paddr,
  input  logic [b64c_pkg::PDATA_W-1:0]   pwdata,
  output logic [b64c_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic           direction_q;
  logic           reg_hit;
  logic           cfg_write;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  b64c_pkg::job_t push_job;
  b64c_pkg::job_t head_job;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[b64c_pkg::PADDR_W-1:2] == b64c_pkg::REG_DIRECTION);
  assign cfg_write = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? {{(b64c_pkg::PDATA_W-1){1'b0}}, direction_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= b64c_pkg::DIR_ENCODE;
    end else if (cfg_write) begin
      direction_q <= pwdata[0];
    end
  end

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .direction_i (direction_q),
    .clear_i     (cfg_write),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .valid_o    (head_valid),
    .head_o     (head_job),
    .pop_i      (pop)
  );

  b64c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned REPORT_MAX      = 10;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned ITEMS_PER_PHASE = 12;
  localparam int unsigned PRESSURE_ITEMS  = 20;
  localparam int unsigned REG_RESERVED    = 1;
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } codec_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       last;
  } codec_result_t;

  logic                          clk;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [b64c_pkg::PADDR_W-1:0]  paddr;
  logic [b64c_pkg::PDATA_W-1:0]  pwdata;
  logic [b64c_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  b64c_in_if  in_if ();
  b64c_out_if out_if ();

  codec_item_t   send_q[$];
  codec_result_t expected_q[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold      = 1'b0;
  logic        hold_armed     = 1'b0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  logic        dir_reg;
  logic [1:0]  grp_pos;
  logic [5:0]  held_sextet;
  logic        held_ok;
  int          sextet_tab [256];

  base64_stream_codec u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    return B64_ALPHABET[s];
  endfunction

  function automatic codec_result_t data_result(input logic [7:0] v);
    codec_result_t r;
    r.value   = v;
    r.present = 1'b1;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic logic [b64c_pkg::PADDR_W-1:0] reg_addr(input int unsigned idx);
    return b64c_pkg::PADDR_W'(idx * 4);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void clear_codec_state();
    grp_pos     = 2'd0;
    held_sextet = 6'd0;
    held_ok     = 1'b0;
  endfunction

  function automatic void apply_config(input int unsigned idx,
                                       input logic [b64c_pkg::PDATA_W-1:0] value);
    if (idx == int'(b64c_pkg::REG_DIRECTION)) begin
      dir_reg = value[0];
      clear_codec_state();
    end
  endfunction

  function automatic void predict_item(input codec_item_t it);
    codec_result_t res[$];
    int            code;
    logic [5:0]    s;
    logic          both;
    if (dir_reg == b64c_pkg::DIR_ENCODE) begin
      case (grp_pos)
        2'd0: begin
          res = {res, data_result(b64_char(it.value[7:2]))};
          held_sextet = {4'b0, it.value[1:0]};
          grp_pos     = 2'd1;
        end
        2'd1: begin
          res = {res, data_result(b64_char({held_sextet[1:0], it.value[7:4]}))};
          held_sextet = {2'b0, it.value[3:0]};
          grp_pos     = 2'd2;
        end
        default: begin
          res = {res, data_result(b64_char({held_sextet[3:0], it.value[7:6]}))};
          res = {res, data_result(b64_char(it.value[5:0]))};
          held_sextet = 6'd0;
          grp_pos     = 2'd0;
        end
      endcase
      if (it.last) begin
        if (grp_pos == 2'd1) begin
          res = {res, data_result(b64_char({held_sextet[1:0], 4'b0}))};
          res = {res, data_result(b64c_pkg::PAD_CHAR)};
          res = {res, data_result(b64c_pkg::PAD_CHAR)};
        end else if (grp_pos == 2'd2) begin
          res = {res, data_result(b64_char({held_sextet[3:0], 2'b0}))};
          res = {res, data_result(b64c_pkg::PAD_CHAR)};
        end
      end
    end else begin
      code = sextet_tab[it.value];
      s    = code[5:0];
      both = (code >= 0) && held_ok;
      if (both) begin
        case (grp_pos)
          2'd1: res = {res, data_result({held_sextet, s[5:4]})};
          2'd2: res = {res, data_result({held_sextet[3:0], s[5:2]})};
          2'd3: res = {res, data_result({held_sextet[1:0], s})};
          default: ;
        endcase
      end
      held_sextet = (code >= 0) ? s : 6'd0;
      held_ok     = (code >= 0);
      grp_pos     = grp_pos + 2'd1;
      if (it.last && res.size() == 0) begin
        res = {codec_result_t'{8'h00, 1'b0, 1'b0}};
      end
    end
    if (it.last) begin
      res[res.size() - 1].last = 1'b1;
      clear_codec_state();
    end
    expected_q = {expected_q, res};
  endfunction

  always @(posedge clk) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_item(send_q.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.valid    <= 1'b1;
          in_if.in_value <= send_q[0].value;
          in_if.in_last  <= send_q[0].last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    codec_result_t got;
    codec_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_value, out_if.out_present, out_if.out_last};
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected transaction: value %02h present %0d last %0d",
                                 got.value, got.present, got.last));
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"result mismatch: expected value %02h present %0d ",
                                    "last %0d, got value %02h present %0d last %0d"},
                                   want.value, want.present, want.last,
                                   got.value, got.present, got.last));
          end
        end
      end
      out_if.ready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // The long receiver hold-off runs on its own cycle count.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(input int unsigned idx,
                           input logic [b64c_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_config(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_direction_readback();
    logic [b64c_pkg::PDATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(b64c_pkg::REG_DIRECTION);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {{(b64c_pkg::PDATA_W - 1){1'b0}}, dir_reg}) begin
      note_failure($sformatf("direction readback: expected %0d, got %08h", dir_reg, got));
    end
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input logic [7:0] v, input logic last);
    codec_item_t it;
    it.value = v;
    it.last  = last;
    send_q = {send_q, it};
  endtask

  task automatic push_text(input string s, input logic last);
    int k;
    for (k = 0; k < s.len(); k++) push_item(s[k], last && (k == s.len() - 1));
  endtask

  task automatic queue_bytes(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) push_item(8'($urandom_range(0, 255)), k == n - 1);
  endtask

  task automatic queue_text_message(input int unsigned n, input int unsigned pads,
                                    input int unsigned noise_pct);
    int unsigned k;
    logic [7:0]  c;
    for (k = 0; k < n; k++) begin
      if (k >= n - pads) c = b64c_pkg::PAD_CHAR;
      else c = b64_char(6'($urandom_range(0, 63)));
      if ($urandom_range(0, 99) < noise_pct) c = 8'($urandom_range(0, 255));
      push_item(c, k == n - 1);
    end
  endtask

  task automatic run_random_phase(input logic dir, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    logic [b64c_pkg::PDATA_W-1:0] cfg;
    int unsigned                  queued;
    int unsigned                  n;
    int unsigned                  pick;
    cfg    = $urandom();
    cfg[0] = dir;
    reg_write(b64c_pkg::REG_DIRECTION, cfg);
    check_direction_readback();
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    @(negedge clk);
    queued = 0;
    while (queued < ITEMS_PER_PHASE) begin
      if (dir == b64c_pkg::DIR_ENCODE) begin
        n = $urandom_range(1, 9);
        queue_bytes(n);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          n = 4 * $urandom_range(1, 3);
          queue_text_message(n, $urandom_range(0, 2), 0);
        end else if (pick < 85) begin
          n = 4 * $urandom_range(1, 3);
          queue_text_message(n, 0, 25);
        end else begin
          n = $urandom_range(1, 9);
          queue_text_message(n, 0, 50);
        end
      end
      queued += n;
    end
    wait_drained();
  endtask

  initial begin
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    int unsigned queued;
    int unsigned n;
    int          k;
    idle_set  = '{0, 75, 0, 34};
    stall_set = '{0, 0, 75, 34};
    clk            = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.in_value = 8'h00;
    in_if.in_last  = 1'b0;
    out_if.ready   = 1'b0;
    dir_reg        = b64c_pkg::DIR_ENCODE;
    clear_codec_state();
    foreach (sextet_tab[i]) sextet_tab[i] = -1;
    for (k = 0; k < 64; k++) sextet_tab[B64_ALPHABET[k]] = k;

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    reg_write(b64c_pkg::REG_DIRECTION,
              {{(b64c_pkg::PDATA_W - 1){1'b0}}, b64c_pkg::DIR_ENCODE});
    check_direction_readback();
    @(negedge clk);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h80, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hA5, 1'b1);
    push_item(8'h4D, 1'b0);
    wait_drained();

    // A message left open is dropped by the direction write.
    reg_write(b64c_pkg::REG_DIRECTION, 32'hFFFF_FFFF);
    check_direction_readback();
    reg_write(REG_RESERVED, 32'h0000_0000);
    check_direction_readback();
    @(negedge clk);
    push_text("TWFu", 1'b1);
    push_text("QQ==", 1'b1);
    push_text("/+9z", 1'b1);
    push_item("Q", 1'b0);
    push_item(8'hC1, 1'b0);
    push_item("z", 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_text("TW", 1'b0);
    wait_drained();
    reg_write(b64c_pkg::REG_DIRECTION,
              {{(b64c_pkg::PDATA_W - 1){1'b0}}, b64c_pkg::DIR_DECODE});
    check_direction_readback();

    reg_write(b64c_pkg::REG_DIRECTION,
              {{(b64c_pkg::PDATA_W - 1){1'b0}}, b64c_pkg::DIR_ENCODE});
    check_direction_readback();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_armed     = 1'b1;
    @(negedge clk);
    queued = 0;
    while (queued < PRESSURE_ITEMS) begin
      n = $urandom_range(2, 8);
      queue_bytes(n);
      queued += n;
    end
    wait_drained();

    for (k = 0; k < 4; k++) begin
      run_random_phase(b64c_pkg::DIR_ENCODE, idle_set[k], stall_set[k]);
      run_random_phase(b64c_pkg::DIR_DECODE, idle_set[k], stall_set[k]);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_in_if.sv
hw/rtl/b64c_out_if.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_fifo.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_stream_codec.sv
tb/tb.sv
